// ===== hw/rtl/ec_point_add_prime_field_macros.svh =====
// assertion macros for the elliptic curve point adder
`ifndef EC_POINT_ADD_PRIME_FIELD_MACROS_SVH
`define EC_POINT_ADD_PRIME_FIELD_MACROS_SVH

// same-cycle implication checked on every clock edge out of reset
`define ECPA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked on every clock edge out of reset
`define ECPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ecpa_pkg.sv =====
// shared types and constants of the elliptic curve point adder
package ecpa_pkg;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_RED,
      OP_DIV
   } ecpa_op_type;

   typedef struct packed {
      ecpa_op_type op;
      logic        bit_in;
   } ecpa_ctl_type;

   localparam logic [1:0] KIND_POINT     = 2'd0;
   localparam logic [1:0] KIND_INFINITY  = 2'd1;
   localparam logic [1:0] KIND_NO_INVERSE = 2'd2;

   localparam logic REG_MODULUS = 1'b0;
   localparam logic REG_CURVE_A = 1'b1;

endpackage

// ===== hw/rtl/ecpa_unit.sv =====
// shared modular add, subtract, reduce and restoring divide step unit
module ecpa_unit #(
   parameter int W = 64
) (
   input  ecpa_pkg::ecpa_ctl_type ctl,
   input  logic [W-1:0]           op_a,
   input  logic [W-1:0]           op_b,
   input  logic [W-1:0]           modulus,
   output logic [W-1:0]           result,
   output logic                   quot_bit
);

   logic [W:0] sum;
   logic [W:0] shifted;

   always_comb begin
      sum      = {1'b0, op_a} + {1'b0, op_b};
      shifted  = {op_a, ctl.bit_in};
      result   = '0;
      quot_bit = 1'b0;
      case (ctl.op)
         ecpa_pkg::OP_ADD: begin
            if (sum >= {1'b0, modulus}) begin
               result = W'(sum - {1'b0, modulus});
            end else begin
               result = sum[W-1:0];
            end
         end
         ecpa_pkg::OP_SUB: begin
            if (op_a >= op_b) begin
               result = op_a - op_b;
            end else begin
               result = op_a - op_b + modulus;
            end
         end
         ecpa_pkg::OP_RED: begin
            if (op_a >= op_b) begin
               result = op_a - op_b;
            end else begin
               result = op_a;
            end
         end
         ecpa_pkg::OP_DIV: begin
            if (shifted >= {1'b0, op_b}) begin
               result   = W'(shifted - {1'b0, op_b});
               quot_bit = 1'b1;
            end else begin
               result   = shifted[W-1:0];
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ec_point_add_prime_field.sv =====
// top level of the affine elliptic curve point adder over a prime field
//
//  port group | direction | transfer when
//  req_*      | in        | req_valid && !req_stall
//  rsp_*      | out       | rsp_valid && !rsp_stall
//  csr_*      | in        | csr_write
//
// steps per item: reduction of the five inputs, then per euclid round a
// divide, a quotient reduce, a multiply and a subtract, then three or four
// multiplies plus single steps between them; all arithmetic uses the shared unit
// reset clears control and loads modulus 11 and curve_a 1
// req_stall is high from acceptance until the result is moved to the output
// register; a stalled result waits there while the next item is taken
`include "ec_point_add_prime_field_macros.svh"
module ec_point_add_prime_field #(
   parameter int FIELD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_first_x,
   input  logic [63:0] req_first_y,
   input  logic [63:0] req_second_x,
   input  logic [63:0] req_second_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_sum_x,
   output logic [63:0] rsp_sum_y,
   output logic [1:0]  rsp_result_kind,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int W  = FIELD_BITS;
   localparam int CW = $clog2(2 * W);

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_MUL, S_RED, S_CHK,
      S_D1, S_D2, S_D3, S_D4, S_N1, S_N2,
      S_INV0, S_ILOOP, S_IQ, S_IT, S_IEND,
      S_L, S_X1, S_X2, S_Y1, S_Y2, S_DONE
   } state_type;

   state_type state_ff, ret_ff;
   logic [CW-1:0] cnt_ff;
   logic [2:0]    k_ff;
   logic [63:0]   modulus_ff, curve_a_ff;
   logic [W-1:0]  x1_ff, y1_ff, x2_ff, y2_ff, a_ff;
   logic [W-1:0]  num_ff, den_ff, lam_ff, x3_ff;
   logic [W-1:0]  r0_ff, r1_ff, t0_ff, t1_ff, rt_ff;
   logic [W-1:0]  mul_a_ff, mul_b_ff, acc_ff;
   logic [W-1:0]  div_n_ff, div_d_ff, rem_ff, quot_ff;
   logic [W-1:0]  res_x_ff, res_y_ff;
   logic [1:0]    res_kind_ff;
   logic          rsp_valid_ff;
   logic [W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [1:0]    rsp_kind_ff;

   logic [W-1:0]  m;
   ecpa_pkg::ecpa_ctl_type ctl;
   logic [W-1:0]  ua, ub, ures;
   logic          uq;

   assign m = modulus_ff[W-1:0];

   always_comb begin
      ctl.op     = ecpa_pkg::OP_ADD;
      ctl.bit_in = 1'b0;
      ua         = '0;
      ub         = '0;
      case (state_ff)
         S_DIV: begin
            ctl.op     = ecpa_pkg::OP_DIV;
            ctl.bit_in = div_n_ff[W-1];
            ua         = rem_ff;
            ub         = div_d_ff;
         end
         S_MUL: begin
            ua = acc_ff;
            ub = cnt_ff[0] ? mul_a_ff : acc_ff;
         end
         S_CHK: begin ua = y1_ff; ub = y2_ff; end
         S_D1:  begin ua = acc_ff; ub = acc_ff; end
         S_D2:  begin ua = num_ff; ub = acc_ff; end
         S_D3:  begin ua = num_ff; ub = a_ff; end
         S_D4:  begin ua = y1_ff; ub = y1_ff; end
         S_N1:  begin ctl.op = ecpa_pkg::OP_SUB; ua = y2_ff; ub = y1_ff; end
         S_N2:  begin ctl.op = ecpa_pkg::OP_SUB; ua = x2_ff; ub = x1_ff; end
         S_IQ:  begin ctl.op = ecpa_pkg::OP_RED; ua = quot_ff; ub = m; end
         S_IT:  begin ctl.op = ecpa_pkg::OP_SUB; ua = t0_ff; ub = acc_ff; end
         S_X1:  begin ctl.op = ecpa_pkg::OP_SUB; ua = acc_ff; ub = x1_ff; end
         S_X2:  begin ctl.op = ecpa_pkg::OP_SUB; ua = x3_ff; ub = x2_ff; end
         S_Y1:  begin ctl.op = ecpa_pkg::OP_SUB; ua = x1_ff; ub = x3_ff; end
         S_Y2:  begin ctl.op = ecpa_pkg::OP_SUB; ua = acc_ff; ub = y1_ff; end
         default: begin
            ua = '0;
         end
      endcase
   end

   ecpa_unit #(.W(W)) u_unit (
      .ctl      (ctl),
      .op_a     (ua),
      .op_b     (ub),
      .modulus  (m),
      .result   (ures),
      .quot_bit (uq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= 64'd11;
         curve_a_ff   <= 64'd1;
         cnt_ff       <= '0;
         k_ff         <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == ecpa_pkg::REG_CURVE_A) begin
               curve_a_ff <= csr_wdata;
            end else begin
               modulus_ff <= csr_wdata;
            end
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x1_ff <= req_first_x[W-1:0];
                  y1_ff <= req_first_y[W-1:0];
                  x2_ff <= req_second_x[W-1:0];
                  y2_ff <= req_second_y[W-1:0];
                  a_ff  <= curve_a_ff[W-1:0];
                  k_ff  <= '0;
                  if (m < W'(3)) begin
                     res_x_ff    <= '0;
                     res_y_ff    <= '0;
                     res_kind_ff <= ecpa_pkg::KIND_NO_INVERSE;
                     state_ff    <= S_DONE;
                  end else begin
                     div_n_ff <= req_first_x[W-1:0];
                     div_d_ff <= m;
                     rem_ff   <= '0;
                     quot_ff  <= '0;
                     cnt_ff   <= '0;
                     ret_ff   <= S_RED;
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               rem_ff   <= ures;
               quot_ff  <= {quot_ff[W-2:0], uq};
               div_n_ff <= div_n_ff << 1;
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(W - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            S_MUL: begin
               if (!cnt_ff[0]) begin
                  acc_ff <= ures;
               end else begin
                  if (mul_b_ff[W-1]) begin
                     acc_ff <= ures;
                  end
                  mul_b_ff <= mul_b_ff << 1;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(2 * W - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            S_RED: begin
               x1_ff <= y1_ff;
               y1_ff <= x2_ff;
               x2_ff <= y2_ff;
               y2_ff <= a_ff;
               a_ff  <= rem_ff;
               k_ff  <= k_ff + 1'b1;
               if (k_ff == 3'd4) begin
                  state_ff <= S_CHK;
               end else begin
                  div_n_ff <= y1_ff;
                  rem_ff   <= '0;
                  quot_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_CHK: begin
               if (x1_ff == x2_ff && ures == '0) begin
                  res_x_ff    <= '0;
                  res_y_ff    <= '0;
                  res_kind_ff <= ecpa_pkg::KIND_INFINITY;
                  state_ff    <= S_DONE;
               end else if (x1_ff == x2_ff && y1_ff == y2_ff) begin
                  mul_a_ff <= x1_ff;
                  mul_b_ff <= x1_ff;
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  ret_ff   <= S_D1;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_N1;
               end
            end
            S_D1: begin num_ff <= ures; state_ff <= S_D2; end
            S_D2: begin num_ff <= ures; state_ff <= S_D3; end
            S_D3: begin num_ff <= ures; state_ff <= S_D4; end
            S_D4: begin den_ff <= ures; state_ff <= S_INV0; end
            S_N1: begin num_ff <= ures; state_ff <= S_N2; end
            S_N2: begin den_ff <= ures; state_ff <= S_INV0; end
            S_INV0: begin
               r0_ff    <= m;
               r1_ff    <= den_ff;
               t0_ff    <= '0;
               t1_ff    <= W'(1);
               state_ff <= S_ILOOP;
            end
            S_ILOOP: begin
               if (r1_ff == '0) begin
                  state_ff <= S_IEND;
               end else begin
                  div_n_ff <= r0_ff;
                  div_d_ff <= r1_ff;
                  rem_ff   <= '0;
                  quot_ff  <= '0;
                  cnt_ff   <= '0;
                  ret_ff   <= S_IQ;
                  state_ff <= S_DIV;
               end
            end
            S_IQ: begin
               rt_ff    <= rem_ff;
               mul_a_ff <= t1_ff;
               mul_b_ff <= ures;
               acc_ff   <= '0;
               cnt_ff   <= '0;
               ret_ff   <= S_IT;
               state_ff <= S_MUL;
            end
            S_IT: begin
               t1_ff    <= ures;
               t0_ff    <= t1_ff;
               r0_ff    <= r1_ff;
               r1_ff    <= rt_ff;
               state_ff <= S_ILOOP;
            end
            S_IEND: begin
               if (r0_ff != W'(1)) begin
                  res_x_ff    <= '0;
                  res_y_ff    <= '0;
                  res_kind_ff <= ecpa_pkg::KIND_NO_INVERSE;
                  state_ff    <= S_DONE;
               end else begin
                  mul_a_ff <= num_ff;
                  mul_b_ff <= t0_ff;
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  ret_ff   <= S_L;
                  state_ff <= S_MUL;
               end
            end
            S_L: begin
               lam_ff   <= acc_ff;
               mul_a_ff <= acc_ff;
               mul_b_ff <= acc_ff;
               acc_ff   <= '0;
               cnt_ff   <= '0;
               ret_ff   <= S_X1;
               state_ff <= S_MUL;
            end
            S_X1: begin x3_ff <= ures; state_ff <= S_X2; end
            S_X2: begin x3_ff <= ures; state_ff <= S_Y1; end
            S_Y1: begin
               mul_a_ff <= lam_ff;
               mul_b_ff <= ures;
               acc_ff   <= '0;
               cnt_ff   <= '0;
               ret_ff   <= S_Y2;
               state_ff <= S_MUL;
            end
            S_Y2: begin
               res_x_ff    <= x3_ff;
               res_y_ff    <= ures;
               res_kind_ff <= ecpa_pkg::KIND_POINT;
               state_ff    <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_x_ff     <= res_x_ff;
                  rsp_y_ff     <= res_y_ff;
                  rsp_kind_ff  <= res_kind_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sum_x       = 64'(rsp_x_ff);
   assign rsp_sum_y       = 64'(rsp_y_ff);
   assign rsp_result_kind = rsp_kind_ff;

   `ECPA_ASSERT_IMPL(a_rem_below_divisor, state_ff == S_DIV, rem_ff < div_d_ff, "remainder out of range")
   `ECPA_ASSERT_IMPL(a_special_zero, rsp_valid_ff && rsp_kind_ff != ecpa_pkg::KIND_POINT, rsp_x_ff == '0 && rsp_y_ff == '0, "special result not zero")
   `ECPA_ASSERT_IMPL(a_kind_legal, rsp_valid_ff, rsp_kind_ff == ecpa_pkg::KIND_POINT || rsp_kind_ff == ecpa_pkg::KIND_INFINITY || rsp_kind_ff == ecpa_pkg::KIND_NO_INVERSE, "bad result kind")
   `ECPA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, state_ff != S_IDLE, "not busy after transfer")

endmodule
